FILE: hdl/ipid4_pkg.sv
// Shared types and constants of the four-channel incremental PID controller.
package ipid4_pkg;

	// Widths fixed by the interface.
	localparam int CH_W      = 2;
	localparam int VEL_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int LIMIT_W   = 15;
	localparam int INC_W     = 16;
	localparam int REG_IDX_W = 2;
	localparam int ERR_W     = VEL_W + 1;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_INC = 2'd3;

	// Register values after reset.
	localparam logic [GAIN_W-1:0]  GAIN_P_RST  = 16'd5734;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST  = 16'd287;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST  = 16'd0;
	localparam logic [LIMIT_W-1:0] MAX_INC_RST = 15'd32767;

	// Error history of one channel: e1 is the last error, e2 the one before.
	typedef struct packed {
		logic signed [ERR_W-1:0] e1;
		logic signed [ERR_W-1:0] e2;
	} hist_t;

endpackage

FILE: hdl/ipid4_hist.sv
// Per-channel error history memory with valid bits and write-to-read forwarding.
module ipid4_hist #(
	parameter int CHANNELS = 4,
	parameter int IDX_W    = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  ipid4_pkg::hist_t  wr_data,
	output ipid4_pkg::hist_t  rd_data
);
	import ipid4_pkg::*;

	hist_t               hist_mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	hist_t               mem_q;
	logic                vld_q;
	logic                hit_q;
	hist_t               byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= hist_mem[rd_addr];
			byp_q <= wr_data;
		end
	end

	// A write landing on the entry being read in the same cycle is forwarded,
	// since the array returns the old contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_q <= valid_q[rd_addr];
				hit_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	always_comb begin
		if (hit_q) begin
			rd_data = byp_q;
		end else if (vld_q) begin
			rd_data = mem_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

FILE: hdl/incremental_pid_four_channel_top.sv
// Top level of the four-channel incremental PID controller.
//
//   port group     | direction | handshake              | contents
//   ---------------+-----------+------------------------+-------------------------------
//   sample in      | in        | in_valid / in_ready    | channel, measured, target
//   increment out  | out       | out_valid / out_ready  | out_channel, increment, saturated
//   configuration  | in        | write_enable           | write_index, write_data
//
// One request is taken every cycle while no result is held back by out_ready; a result
// passes in order through the history read, products, sum and truncation, and the clamp
// into the output register, each step registered.
// Back-to-back requests on one channel are served by forwarding the history write.
// Reset clears the control state and marks every channel's history as zero.
// The whole pipeline holds while a result waits and out_ready is low.
module incremental_pid_four_channel_top #(
	parameter int CHANNELS       = 4,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [ipid4_pkg::CH_W-1:0]             channel,
	input  logic signed [ipid4_pkg::VEL_W-1:0]     measured,
	input  logic signed [ipid4_pkg::VEL_W-1:0]     target,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [ipid4_pkg::CH_W-1:0]             out_channel,
	output logic signed [ipid4_pkg::INC_W-1:0]     increment,
	output logic                                   saturated,
	input  logic                                   write_enable,
	input  logic [ipid4_pkg::REG_IDX_W-1:0]        write_index,
	input  logic [ipid4_pkg::GAIN_W-1:0]           write_data
);
	import ipid4_pkg::*;

	localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DP_W    = ERR_W + 1;
	localparam int DD_W    = ERR_W + 2;
	localparam int PP_W    = GAIN_W + 1 + DP_W;
	localparam int PI_W    = GAIN_W + 1 + ERR_W;
	localparam int PD_W    = GAIN_W + 1 + DD_W;
	localparam int SUM_W   = PD_W + 1;
	localparam int DELTA_W = SUM_W - GAIN_FRAC_BITS;
	localparam logic [SUM_W-1:0] FRAC_MASK = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

	// Configuration registers.
	logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [LIMIT_W-1:0] max_inc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= GAIN_P_RST;
			gain_i_q  <= GAIN_I_RST;
			gain_d_q  <= GAIN_D_RST;
			max_inc_q <= MAX_INC_RST;
		end else if (write_enable) begin
			unique case (write_index)
				REG_GAIN_P:  gain_p_q  <= write_data;
				REG_GAIN_I:  gain_i_q  <= write_data;
				REG_GAIN_D:  gain_d_q  <= write_data;
				REG_MAX_INC: max_inc_q <= write_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline control: every stage moves when the output register can move.
	logic adv, acc;
	logic v_s1, v_s2, v_s3, out_valid_q;

	assign adv      = !out_valid_q || out_ready;
	assign acc      = in_valid && adv;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Stage 0: form the error and start the history read.
	logic                    ch_ok_in;
	logic signed [ERR_W-1:0] e_in;

	assign ch_ok_in = (32'(channel) < 32'(CHANNELS));
	assign e_in     = ERR_W'(target) - ERR_W'(measured);

	logic [CH_W-1:0]         ch_s1;
	logic                    ok_s1;
	logic signed [ERR_W-1:0] e_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1 <= channel;
			ok_s1 <= ch_ok_in;
			e_s1  <= e_in;
		end
	end

	hist_t hist_rd, hist_wr;
	logic  wr_en;

	// Channels beyond the configured count see a zero history and leave no trace.
	assign wr_en      = adv && v_s1 && ok_s1;
	assign hist_wr.e1 = e_s1;
	assign hist_wr.e2 = ok_s1 ? hist_rd.e1 : '0;

	ipid4_hist #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc && ch_ok_in),
		.rd_addr (IDX_W'(channel)),
		.wr_en   (wr_en),
		.wr_addr (IDX_W'(ch_s1)),
		.wr_data (hist_wr),
		.rd_data (hist_rd)
	);

	// Stage 1: differences and the three products.
	logic signed [ERR_W-1:0] e1_s1, e2_s1;
	logic signed [DP_W-1:0]  dp_s1;
	logic signed [DD_W-1:0]  dd_s1;
	logic signed [PP_W-1:0]  prod_p;
	logic signed [PI_W-1:0]  prod_i;
	logic signed [PD_W-1:0]  prod_d;

	assign e1_s1  = ok_s1 ? hist_rd.e1 : '0;
	assign e2_s1  = ok_s1 ? hist_rd.e2 : '0;
	assign dp_s1  = DP_W'(e_s1) - DP_W'(e1_s1);
	assign dd_s1  = DD_W'(e_s1) - (DD_W'(e1_s1) <<< 1) + DD_W'(e2_s1);
	assign prod_p = $signed({1'b0, gain_p_q}) * dp_s1;
	assign prod_i = $signed({1'b0, gain_i_q}) * e_s1;
	assign prod_d = $signed({1'b0, gain_d_q}) * dd_s1;

	logic [CH_W-1:0]        ch_s2;
	logic signed [PP_W-1:0] prod_p_s2;
	logic signed [PI_W-1:0] prod_i_s2;
	logic signed [PD_W-1:0] prod_d_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s2     <= ch_s1;
			prod_p_s2 <= prod_p;
			prod_i_s2 <= prod_i;
			prod_d_s2 <= prod_d;
		end
	end

	// Stage 2: exact sum, then division by the gain scale rounding toward zero.
	logic signed [SUM_W-1:0] sum_s2, biased_s2;

	assign sum_s2    = SUM_W'(prod_p_s2) + SUM_W'(prod_i_s2) + SUM_W'(prod_d_s2);
	assign biased_s2 = sum_s2 + (sum_s2[SUM_W-1] ? FRAC_MASK : '0);

	logic [CH_W-1:0]           ch_s3;
	logic signed [DELTA_W-1:0] delta_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s3    <= ch_s2;
			delta_s3 <= biased_s2[SUM_W-1:GAIN_FRAC_BITS];
		end
	end

	// Stage 3: clamp to the increment limit.
	logic signed [DELTA_W-1:0] lim, neg_lim;
	logic signed [INC_W-1:0]   inc_next;
	logic                      sat_next;

	assign lim     = DELTA_W'($signed({1'b0, max_inc_q}));
	assign neg_lim = -lim;

	always_comb begin
		priority if (delta_s3 > lim) begin
			inc_next = lim[INC_W-1:0];
			sat_next = 1'b1;
		end else if (delta_s3 < neg_lim) begin
			inc_next = neg_lim[INC_W-1:0];
			sat_next = 1'b1;
		end else begin
			inc_next = delta_s3[INC_W-1:0];
			sat_next = 1'b0;
		end
	end

	logic [CH_W-1:0]         out_ch_q;
	logic signed [INC_W-1:0] inc_q;
	logic                    sat_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch_q <= ch_s3;
			inc_q    <= inc_next;
			sat_q    <= sat_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign increment   = inc_q;
	assign saturated   = sat_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the four-channel incremental PID controller.
`timescale 1ns / 1ps

module testbench;
	import ipid4_pkg::*;

	localparam int NUM_CH    = 4;
	localparam int FRAC_BITS = 12;

	typedef struct {
		logic [CH_W-1:0]         ch;
		logic signed [VEL_W-1:0] meas;
		logic signed [VEL_W-1:0] tgt;
	} sample_t;

	typedef struct {
		logic [CH_W-1:0]         ch;
		logic signed [INC_W-1:0] inc;
		logic                    sat;
	} inc_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CH_W-1:0] channel = '0;
	logic signed [VEL_W-1:0] measured = '0;
	logic signed [VEL_W-1:0] target = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CH_W-1:0] out_channel;
	logic signed [INC_W-1:0] increment;
	logic saturated;
	logic write_enable = 1'b0;
	logic [REG_IDX_W-1:0] write_index = '0;
	logic [GAIN_W-1:0] write_data = '0;

	// Shadow copies of the registers and of each channel's error history.
	logic [GAIN_W-1:0] kp = GAIN_P_RST;
	logic [GAIN_W-1:0] ki = GAIN_I_RST;
	logic [GAIN_W-1:0] kd = GAIN_D_RST;
	logic [LIMIT_W-1:0] inc_limit = MAX_INC_RST;
	logic signed [ERR_W-1:0] err_last [NUM_CH];
	logic signed [ERR_W-1:0] err_before [NUM_CH];

	sample_t pending_samples [$];
	inc_t expected_incs [$];
	sample_t held_sample;
	inc_t got_inc;
	inc_t want_inc;
	int in_gap = 0;
	int out_gap = 0;
	int stall_odds = 0;
	bit failed = 1'b0;
	logic signed [VEL_W-1:0] set_point [NUM_CH];

	incremental_pid_four_channel_top #(
		.CHANNELS(NUM_CH),
		.GAIN_FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.channel(channel),
		.measured(measured),
		.target(target),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_channel(out_channel),
		.increment(increment),
		.saturated(saturated),
		.write_enable(write_enable),
		.write_index(write_index),
		.write_data(write_data)
	);

	always #1 clk = ~clk;

	// Works out the increment of one request and shifts that channel's history.
	function automatic inc_t predict_increment(sample_t s);
		longint e;
		longint e1;
		longint e2;
		longint acc;
		longint delta;
		longint lim;
		inc_t r;
		e = longint'(s.tgt) - longint'(s.meas);
		e1 = 0;
		e2 = 0;
		if (int'(s.ch) < NUM_CH) begin
			e1 = longint'(err_last[s.ch]);
			e2 = longint'(err_before[s.ch]);
		end
		acc = longint'(kp) * (e - e1) + longint'(ki) * e
			+ longint'(kd) * (e - 2 * e1 + e2);
		delta = acc / (longint'(1) << FRAC_BITS);
		lim = longint'(inc_limit);
		r.sat = 1'b0;
		if (delta > lim) begin
			delta = lim;
			r.sat = 1'b1;
		end else if (delta < -lim) begin
			delta = -lim;
			r.sat = 1'b1;
		end
		if (int'(s.ch) < NUM_CH) begin
			err_before[s.ch] = err_last[s.ch];
			err_last[s.ch] = ERR_W'(e);
		end
		r.ch = s.ch;
		r.inc = INC_W'(delta);
		return r;
	endfunction

	function automatic bit stall_now();
		return stall_odds != 0 && $urandom_range(1, stall_odds) == 1;
	endfunction

	// Request driver: a new request goes out once the previous one has been taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			channel <= '0;
			measured <= '0;
			target <= '0;
			in_gap = 0;
			for (int c = 0; c < NUM_CH; c++) begin
				err_last[c] = '0;
				err_before[c] = '0;
			end
		end else begin
			if (in_valid && in_ready)
				expected_incs.push_back(predict_increment(held_sample));
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0 && stall_now()) begin
					in_gap = $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					held_sample = pending_samples.pop_front();
					channel <= held_sample.ch;
					measured <= held_sample.meas;
					target <= held_sample.tgt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				got_inc.ch = out_channel;
				got_inc.inc = increment;
				got_inc.sat = saturated;
				if (expected_incs.size() == 0) begin
					$error("increment with none expected: channel %0d, increment %0d",
						got_inc.ch, got_inc.inc);
					failed = 1'b1;
				end else begin
					want_inc = expected_incs.pop_front();
					if (got_inc.ch !== want_inc.ch) begin
						$error("out_channel: expected %0d, got %0d", want_inc.ch, got_inc.ch);
						failed = 1'b1;
					end
					if (got_inc.inc !== want_inc.inc) begin
						$error("increment: expected %0d, got %0d", want_inc.inc, got_inc.inc);
						failed = 1'b1;
					end
					if (got_inc.sat !== want_inc.sat) begin
						$error("saturated: expected %0d, got %0d", want_inc.sat, got_inc.sat);
						failed = 1'b1;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (stall_now()) begin
				out_gap = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_sample(input int ch, input int meas, input int tgt);
		sample_t s;
		s.ch = CH_W'(ch);
		s.meas = VEL_W'(meas);
		s.tgt = VEL_W'(tgt);
		pending_samples.push_back(s);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		@(posedge clk);
		write_enable <= 1'b1;
		write_index <= idx;
		write_data <= data;
	endtask

	// Only called while the block is idle, so the shadow copies may change at once.
	task automatic set_registers(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
			input logic [GAIN_W-1:0] d, input logic [LIMIT_W-1:0] lim);
		write_reg(REG_GAIN_P, p);
		write_reg(REG_GAIN_I, i);
		write_reg(REG_GAIN_D, d);
		write_reg(REG_MAX_INC, {1'b0, lim});
		@(posedge clk);
		write_enable <= 1'b0;
		kp = p;
		ki = i;
		kd = d;
		inc_limit = lim;
	endtask

	// Waits until every request has been taken and every increment checked.
	task automatic drain();
		while (pending_samples.size() != 0 || in_valid || expected_incs.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return GAIN_W'($urandom_range(0, 8191));
			default: return GAIN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [LIMIT_W-1:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return LIMIT_W'($urandom_range(1, 255));
			default: return LIMIT_W'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(0, 3))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	// Half the time a measurement near its channel's set point with noise, else random values or extremes.
	task automatic push_random_sample();
		int ch;
		int tgt;
		ch = $urandom_range(0, NUM_CH - 1);
		case ($urandom_range(0, 7))
			0: push_sample(ch, pick_extreme(), pick_extreme());
			1, 2, 3: push_sample(ch, $urandom_range(0, 65535), $urandom_range(0, 65535));
			default: begin
				if ($urandom_range(0, 31) == 0)
					set_point[ch] = VEL_W'($urandom_range(0, 65535));
				tgt = int'(set_point[ch]);
				push_sample(ch, tgt + $urandom_range(0, 1023) - 512, tgt);
			end
		endcase
	endtask

	initial begin
		for (int c = 0; c < NUM_CH; c++)
			set_point[c] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset gains: extreme errors of both signs, back to back on one channel.
		stall_odds = 3;
		push_sample(0, 0, 0);
		push_sample(1, -32768, 32767);
		push_sample(1, 32767, -32768);
		push_sample(2, 100, -100);
		push_sample(3, -1, -1);
		push_sample(0, 1000, 1200);
		push_sample(0, 1000, 1100);
		drain();

		// Largest gains: saturation in both directions.
		set_registers('1, '1, '1, '1);
		push_sample(0, -32768, 32767);
		push_sample(0, 32767, -32768);
		push_sample(1, 0, 1);
		push_sample(2, 0, -1);
		drain();

		// Zero limit: every increment is zero, flagged when the delta was not.
		set_registers(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, '0);
		push_sample(3, 0, 0);
		push_sample(3, 0, 5000);
		push_sample(2, 5000, 0);
		drain();

		set_registers('0, '0, '0, '1);
		push_sample(1, -32768, 32767);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 9) begin
				stall_odds = 0;
				set_registers(GAIN_P_RST, GAIN_I_RST, 16'd1024, MAX_INC_RST);
			end else begin
				case ($urandom_range(0, 3))
					0: stall_odds = 0;
					1: stall_odds = 2;
					2: stall_odds = 4;
					default: stall_odds = 8;
				endcase
				set_registers(pick_gain(), pick_gain(), pick_gain(), pick_limit());
			end
			for (int c = 0; c < NUM_CH; c++)
				set_point[c] = VEL_W'($urandom_range(0, 65535));
			for (int n = 0; n < 200; n++)
				push_random_sample();
			drain();
		end

		if (!failed)
			$display("incremental_pid_four_channel_top: match");
		else
			$display("incremental_pid_four_channel_top: mismatch");
		$finish;
	end

	initial begin
		#400000;
		$display("incremental_pid_four_channel_top: mismatch");
		$finish;
	end

endmodule
